// ===== rtl/sctc_pkg.sv =====
// Package: shared types and constants of the sector cache tag controller.
`default_nettype none

package sctc_pkg;

  localparam logic [31:0] TAG_EMPTY = 32'hFFFF_FFFF;
  localparam int          READAHEAD = 16;
  localparam int          MAX_COUNT = 256;
  localparam int          CNT_W     = 9;

  localparam logic [1:0] FN_LOOKUP   = 2'd0;
  localparam logic [1:0] FN_INSTALL  = 2'd1;
  localparam logic [1:0] FN_INVRANGE = 2'd2;
  localparam logic [1:0] FN_INVALL   = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      start_sector;
    logic [CNT_W-1:0] sector_count;
  } sctc_req_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] slot;
    logic [4:0] fill_count;
  } sctc_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED,
    ST_LOOK,
    ST_INST,
    ST_INVR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/sector_cache_tag_controller_top.sv =====
// Sector cache tag controller: slot reduction, tag memory and operation sequencer.
// Lookup: tag read in ST_RED, result registered in ST_LOOK; next request taken back in ST_IDLE.
// Install of N sectors: one tag write per cycle in ST_INST, result then registered in ST_DONE.
// Invalidate range of N sectors: pipelined read/compare/write in ST_INVR, result from ST_DONE.
// Invalidate all: one entry per cycle in the clearing pass, result registered in ST_DONE.
// Reset: synchronous; a clearing pass over all ENTRIES slots follows, requests held off.
`default_nettype none

module sector_cache_tag_controller_top #(
  parameter int ENTRIES = 128
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  output logic                     req_stall,
  input  wire sctc_pkg::sctc_req_t req,
  output logic                     rsp_valid,
  input  wire                      rsp_stall,
  output sctc_pkg::sctc_rsp_t      rsp
);
  import sctc_pkg::*;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W  = SLOT_W + 3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
  localparam logic [SUM_W-1:0]  E1 = SUM_W'(ENTRIES);
  localparam logic [SUM_W-1:0]  E2 = SUM_W'(2 * ENTRIES);
  localparam logic [SUM_W-1:0]  E4 = SUM_W'(4 * ENTRIES);

  // Residue of one nibble at its place in the sector number.
  function automatic int nib_res(int k, int n);
    longint v;
    v = longint'(n) << (4 * k);
    return int'(v % ENTRIES);
  endfunction

  logic [SLOT_W-1:0] nib_tab [8][16];

  for (genvar k = 0; k < 8; k++) begin : g_nib
    for (genvar n = 0; n < 16; n++) begin : g_val
      assign nib_tab[k][n] = SLOT_W'(nib_res(k, n));
    end
  end

  logic [31:0] tag_mem [ENTRIES];

  state_t             state, state_next;
  logic [1:0]         req_func;
  logic [31:0]        cur_sec;
  logic [CNT_W-1:0]   rem;
  logic [SUM_W-1:0]   sum_r;
  logic [SLOT_W-1:0]  cur_slot;
  logic               clr_result;
  logic               pend;
  logic [SLOT_W-1:0]  pend_slot;
  logic [31:0]        pend_sec;
  logic [31:0]        rdata;

  logic [SUM_W-1:0]   sum_in;
  logic [SUM_W-1:0]   red_a, red_b, red_c;
  logic [SLOT_W-1:0]  red_slot;
  logic [SLOT_W-1:0]  slot_inc;
  logic [CNT_W-1:0]   cnt_sat;
  logic               out_free;
  logic               lookup_hit;

  logic               mem_we, mem_re;
  logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata;

  always_comb begin
    sum_in = '0;
    for (int k = 0; k < 8; k++) begin
      sum_in = sum_in + SUM_W'(nib_tab[k][req.start_sector[4*k +: 4]]);
    end
  end

  // Fold the nibble sum below ENTRIES.
  always_comb begin
    red_a    = (sum_r >= E4) ? sum_r - E4 : sum_r;
    red_b    = (red_a >= E2) ? red_a - E2 : red_a;
    red_c    = (red_b >= E1) ? red_b - E1 : red_b;
    red_slot = red_c[SLOT_W-1:0];
  end

  assign slot_inc   = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
  assign cnt_sat    = (int'(req.sector_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT)
                                                          : req.sector_count;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign lookup_hit = (cur_sec != TAG_EMPTY) && (rdata == cur_sec);
  assign req_stall  = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cur_slot == LAST_SLOT) state_next = clr_result ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.func == FN_INVALL) ? ST_CLEAR : ST_RED;
        end
      end
      ST_RED: begin
        case (req_func)
          FN_LOOKUP:   state_next = ST_LOOK;
          FN_INSTALL:  state_next = ST_INST;
          FN_INVRANGE: state_next = ST_INVR;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_INST: if (rem == '0) state_next = ST_DONE;
      ST_INVR: if (rem == '0 && !pend) state_next = ST_DONE;
      ST_LOOK: if (out_free) state_next = ST_IDLE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur_slot;
    mem_raddr = cur_slot;
    mem_wdata = TAG_EMPTY;
    case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_RED: begin
        mem_re    = (req_func == FN_LOOKUP);
        mem_raddr = red_slot;
      end
      ST_INST: begin
        mem_we    = (rem != '0);
        mem_wdata = cur_sec;
      end
      ST_INVR: begin
        mem_re    = (rem != '0);
        mem_we    = pend && (rdata == pend_sec);
        mem_waddr = pend_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= tag_mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur_slot   <= '0;
      clr_result <= 1'b0;
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: cur_slot <= slot_inc;
        ST_IDLE: begin
          if (req_valid) begin
            cur_slot   <= '0;
            clr_result <= 1'b1;
            pend       <= 1'b0;
          end
        end
        ST_RED:  cur_slot <= red_slot;
        // wrap to the slot of sector zero at the top of the sector space
        ST_INST: if (rem != '0) cur_slot <= (&cur_sec) ? '0 : slot_inc;
        ST_INVR: begin
          pend <= (rem != '0);
          if (rem != '0) cur_slot <= (&cur_sec) ? '0 : slot_inc;
        end
        default: ;
      endcase
      if ((state == ST_LOOK || state == ST_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_func <= req.func;
          cur_sec  <= req.start_sector;
          rem      <= cnt_sat;
          sum_r    <= sum_in;
        end
      end
      ST_INST: begin
        if (rem != '0) begin
          cur_sec <= cur_sec + 32'd1;
          rem     <= rem - 1'b1;
        end
      end
      ST_INVR: begin
        pend_sec  <= cur_sec;
        pend_slot <= cur_slot;
        if (rem != '0) begin
          cur_sec <= cur_sec + 32'd1;
          rem     <= rem - 1'b1;
        end
      end
      default: ;
    endcase
    if (state == ST_LOOK && out_free) begin
      rsp.hit        <= lookup_hit;
      rsp.slot       <= 7'(cur_slot);
      rsp.fill_count <= lookup_hit ? 5'd0 : 5'(READAHEAD);
    end else if (state == ST_DONE && out_free) begin
      rsp <= '0;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken during clearing pass");

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("tag read and write hit the same slot in one cycle");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.fill_count == 5'd0))
    else $error("hit result asks for a fill");
`endif

endmodule

`default_nettype wire
